>>> src/rbws_pkg.sv
// Shared types, constants and helper functions of the retry backoff write scheduler.
package rbws_pkg;

  localparam int SLOTS   = 2;
  localparam int KINDS   = 3;
  localparam int NENT    = SLOTS * KINDS;
  localparam int IDX_W   = $clog2(NENT);
  localparam int VALUE_W = 24;
  localparam int TIME_W  = 32;
  localparam int FAIL_W  = 8;
  localparam int SENDS_W = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int GAP_W      = 10;
  localparam int RESEND_W   = 12;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESEND = 2'd2;

  localparam logic [1:0] TGT_BOTH  = 2'd0;
  localparam logic [1:0] TGT_SLOT0 = 2'd1;
  localparam logic [1:0] TGT_SLOT1 = 2'd2;
  localparam logic [1:0] TGT_SPARE = 2'd3;

  localparam logic MODE_ENQ  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [1:0] KIND_POWER  = 2'd0;
  localparam logic [1:0] KIND_BRIGHT = 2'd1;
  localparam logic [1:0] KIND_COLOR  = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  localparam logic [GAP_W-1:0]    GAP_RESET    = 10'd18;
  localparam logic [RESEND_W-1:0] RESEND_RESET = 12'd100;

  localparam logic [VALUE_W-1:0] BRIGHT_MAX     = 24'd100;
  localparam logic [TIME_W-1:0]  FAIL_BASE_MS   = 32'd250;
  localparam logic [TIME_W-1:0]  FAIL_CAP_MS    = 32'd5000;
  localparam logic [FAIL_W-1:0]  FAIL_MAX_SHIFT = 8'd4;
  localparam logic [FAIL_W-1:0]  FAIL_SAT       = 8'd255;

  localparam logic [SENDS_W-1:0] SENDS_RELIABLE = 2'd2;
  localparam logic [SENDS_W-1:0] SENDS_SINGLE   = 2'd1;

  // One stored command entry
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [SENDS_W-1:0] sends_left;
    logic [FAIL_W-1:0]  failures;
    logic [TIME_W-1:0]  due;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Configuration register contents
  typedef struct packed {
    logic [1:0]          target;
    logic [GAP_W-1:0]    min_gap;
    logic [RESEND_W-1:0] resend;
  } cfg_t;

  // Wait after a failed write: 250 ms shifted left by up to four, capped
  function automatic logic [TIME_W-1:0] backoff_ms(input logic [FAIL_W-1:0] fails);
    logic [2:0]        shift;
    logic [TIME_W-1:0] wait_ms;
    shift = 3'd0;
    if (fails > 8'd1) begin
      if ((fails - 8'd1) > FAIL_MAX_SHIFT) begin
        shift = FAIL_MAX_SHIFT[2:0];
      end else begin
        shift = 3'(fails - 8'd1);
      end
    end
    wait_ms = FAIL_BASE_MS << shift;
    return (wait_ms < FAIL_CAP_MS) ? wait_ms : FAIL_CAP_MS;
  endfunction

  // Flat entry index slot*KINDS+kind
  function automatic logic [IDX_W-1:0] entry_index(input logic slot, input logic [1:0] kind);
    return slot ? (IDX_W'(kind) + IDX_W'(KINDS)) : IDX_W'(kind);
  endfunction

endpackage

>>> src/rbws_if.sv
// Request and result channel interfaces of the retry backoff write scheduler.
interface rbws_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [rbws_pkg::TIME_W-1:0]  now_ms;
  logic [1:0]                   link_up;
  logic [1:0]                   cmd_kind;
  logic [rbws_pkg::VALUE_W-1:0] cmd_value;
  logic                         reliable;
  logic                         write_ok;

  modport source (
    output valid, mode, now_ms, link_up, cmd_kind, cmd_value, reliable, write_ok,
    input  ready
  );
  modport sink (
    input  valid, mode, now_ms, link_up, cmd_kind, cmd_value, reliable, write_ok,
    output ready
  );
endinterface

interface rbws_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         write_issued;
  logic                         write_slot;
  logic [1:0]                   write_kind;
  logic [rbws_pkg::VALUE_W-1:0] write_value;

  modport source (
    output valid, write_issued, write_slot, write_kind, write_value,
    input  ready
  );
  modport sink (
    input  valid, write_issued, write_slot, write_kind, write_value,
    output ready
  );
endinterface

>>> src/retry_backoff_write_scheduler_unit.sv
// Top level of the retry backoff write scheduler: configuration registers and sequencer.
//
// Usage:
//   req carries one request per handshake: an enqueue (mode 0) stores a latest-value
//   command per kind for each targeted, connected slot; a service tick (mode 1) may
//   issue one link write and carries the outcome of that write in write_ok.
//   rsp returns exactly one result per request; write_issued tells whether a write
//   went out, and slot, kind and value are zero otherwise.
//   The configuration port writes target_select (0), min_write_gap (1) and
//   resend_delay (2) on any cycle with cfg_we high; a change of target drops all
//   stored commands. Write it only while no request is in flight.
// Sequencing:
//   An enqueue visits ST_ENQ once per slot; ST_DONE then loads the output register.
//   A tick runs a gap check, at most one scan step per entry and one check step per
//   pending entry, as the entry RAM read data is registered, then ST_DONE as well.
//   The next request is accepted back in ST_IDLE; one request is worked on at a time.
// Reset and stall:
//   Synchronous reset clears all pending flags, the last write time, the slot pointer
//   and the valid flag of the result register; configuration returns to 0, 18 and 100.
//   A stalled receiver holds the result in the output register; the next request
//   is still accepted and worked on, and waits only to hand over its own result.
module retry_backoff_write_scheduler_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rbws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbws_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  rbws_req_if.sink                           req,
  rbws_rsp_if.source                         rsp
);

  rbws_pkg::cfg_t cfg;
  logic [1:0]     target_norm;
  logic           clear_all;

  // Map the spare target code onto both slots; flag a real change of target
  always_comb begin
    target_norm = (cfg_wdata[1:0] == rbws_pkg::TGT_SPARE) ? rbws_pkg::TGT_BOTH
                                                           : cfg_wdata[1:0];
    clear_all   = cfg_we && (cfg_index == rbws_pkg::REG_TARGET)
               && (target_norm != cfg.target);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target  <= rbws_pkg::TGT_BOTH;
      cfg.min_gap <= rbws_pkg::GAP_RESET;
      cfg.resend  <= rbws_pkg::RESEND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rbws_pkg::REG_TARGET: cfg.target  <= target_norm;
        rbws_pkg::REG_GAP:    cfg.min_gap <= cfg_wdata[rbws_pkg::GAP_W-1:0];
        rbws_pkg::REG_RESEND: cfg.resend  <= cfg_wdata[rbws_pkg::RESEND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rbws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clear_all (clear_all),
    .req       (req),
    .rsp       (rsp)
  );

endmodule

>>> src/rbws_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rbws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/rbws_ctrl.sv
// Sequencer: enqueue writes, gap check, entry scan, retry update and result register.
module rbws_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  rbws_pkg::cfg_t cfg,
  input  logic           clear_all,
  rbws_req_if.sink       req,
  rbws_rsp_if.source     rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_GAP,
    ST_SCAN,
    ST_CHECK,
    ST_DONE
  } state_t;

  state_t state;

  // Latched request
  logic [rbws_pkg::TIME_W-1:0]  now_q;
  logic [1:0]                   link_q;
  logic [1:0]                   kind_q;
  logic [rbws_pkg::VALUE_W-1:0] value_q;
  logic                         rel_q;
  logic                         ok_q;

  // Scheduler state held in flops
  logic [rbws_pkg::NENT-1:0]   pending;
  logic [rbws_pkg::TIME_W-1:0] last_write_time;
  logic                        next_slot;

  // Scan position
  logic       pass_q;
  logic [1:0] k_q;
  logic       enq_slot;

  // Pending result and output register
  logic                         res_issued;
  logic                         res_slot;
  logic [1:0]                   res_kind;
  logic [rbws_pkg::VALUE_W-1:0] res_value;
  logic                         out_valid;
  logic                         out_issued;
  logic                         out_slot;
  logic [1:0]                   out_kind;
  logic [rbws_pkg::VALUE_W-1:0] out_value;

  // Memory port signals
  logic                          ram_we;
  logic [rbws_pkg::IDX_W-1:0]    ram_waddr;
  logic [rbws_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [rbws_pkg::ENTRY_W-1:0]  ram_rdata;

  // Request normalization
  logic [1:0]                   in_kind;
  logic [rbws_pkg::VALUE_W-1:0] in_value;

  // Derived control
  logic                          cur_slot;
  logic [rbws_pkg::IDX_W-1:0]    cur_idx;
  logic [rbws_pkg::IDX_W-1:0]    enq_idx;
  logic                          enq_targeted;
  logic                          enq_hit;
  logic                          slot_down;
  logic [rbws_pkg::TIME_W-1:0]   gap_diff;
  logic [rbws_pkg::TIME_W-1:0]   due_diff;
  logic                          entry_due;
  logic                          scan_last;
  rbws_pkg::entry_t              rd_entry;
  rbws_pkg::entry_t              upd_entry;
  rbws_pkg::entry_t              enq_entry;
  logic [rbws_pkg::SENDS_W-1:0]  sends_dec;
  logic [rbws_pkg::FAIL_W-1:0]   fails_inc;

  rbws_ram #(
    .WIDTH (rbws_pkg::ENTRY_W),
    .DEPTH (rbws_pkg::NENT)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_idx),
    .rdata (ram_rdata)
  );

  // Normalize kind and value of an incoming command
  always_comb begin
    in_kind = (req.cmd_kind == rbws_pkg::KIND_SPARE) ? rbws_pkg::KIND_COLOR : req.cmd_kind;
    in_value = req.cmd_value;
    case (in_kind)
      rbws_pkg::KIND_POWER: begin
        in_value = (req.cmd_value != '0) ? rbws_pkg::VALUE_W'(1) : '0;
      end
      rbws_pkg::KIND_BRIGHT: begin
        if (req.cmd_value > rbws_pkg::BRIGHT_MAX) begin
          in_value = rbws_pkg::BRIGHT_MAX;
        end
      end
      default: begin
        in_value = req.cmd_value;
      end
    endcase
  end

  // Scan and enqueue addressing
  always_comb begin
    cur_slot     = next_slot ^ pass_q;
    cur_idx      = rbws_pkg::entry_index(cur_slot, k_q);
    enq_idx      = rbws_pkg::entry_index(enq_slot, kind_q);
    enq_targeted = (cfg.target == rbws_pkg::TGT_BOTH)
                || (!enq_slot && cfg.target == rbws_pkg::TGT_SLOT0)
                || (enq_slot && cfg.target == rbws_pkg::TGT_SLOT1);
    enq_hit      = enq_targeted && link_q[enq_slot];
    slot_down    = !link_q[cur_slot];
    scan_last    = pass_q && (k_q == rbws_pkg::KIND_COLOR);
    gap_diff     = now_q - last_write_time;
  end

  // Due test and retry update of the entry just read
  always_comb begin
    rd_entry  = rbws_pkg::entry_t'(ram_rdata);
    due_diff  = now_q - rd_entry.due;
    entry_due = !due_diff[rbws_pkg::TIME_W-1];
    sends_dec = (rd_entry.sends_left != '0) ? rd_entry.sends_left - 2'd1 : '0;
    fails_inc = (rd_entry.failures == rbws_pkg::FAIL_SAT)
              ? rbws_pkg::FAIL_SAT : rd_entry.failures + 8'd1;
    upd_entry = rd_entry;
    if (ok_q) begin
      upd_entry.failures   = '0;
      upd_entry.sends_left = sends_dec;
      upd_entry.due        = now_q + rbws_pkg::TIME_W'(cfg.resend);
    end else begin
      upd_entry.failures = fails_inc;
      upd_entry.due      = now_q + rbws_pkg::backoff_ms(fails_inc);
    end
  end

  // Memory write port: enqueue fill or retry update
  always_comb begin
    enq_entry.value      = value_q;
    enq_entry.sends_left = rel_q ? rbws_pkg::SENDS_RELIABLE : rbws_pkg::SENDS_SINGLE;
    enq_entry.failures   = '0;
    enq_entry.due        = now_q;
    if (state == ST_ENQ) begin
      ram_we    = enq_hit;
      ram_waddr = enq_idx;
      ram_wdata = enq_entry;
    end else begin
      ram_we    = (state == ST_CHECK) && entry_due;
      ram_waddr = cur_idx;
      ram_wdata = upd_entry;
    end
  end

  // Sequencer, scheduler flops and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      pending         <= '0;
      last_write_time <= '0;
      next_slot       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      if (clear_all) begin
        pending <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            now_q      <= req.now_ms;
            link_q     <= req.link_up;
            kind_q     <= in_kind;
            value_q    <= in_value;
            rel_q      <= req.reliable;
            ok_q       <= req.write_ok;
            pass_q     <= 1'b0;
            k_q        <= rbws_pkg::KIND_POWER;
            enq_slot   <= 1'b0;
            res_issued <= 1'b0;
            res_slot   <= 1'b0;
            res_kind   <= rbws_pkg::KIND_POWER;
            res_value  <= '0;
            state      <= (req.mode == rbws_pkg::MODE_ENQ) ? ST_ENQ : ST_GAP;
          end
        end
        ST_ENQ: begin
          if (enq_hit) begin
            pending[enq_idx] <= 1'b1;
          end
          if (enq_slot) begin
            state <= ST_DONE;
          end else begin
            enq_slot <= 1'b1;
          end
        end
        ST_GAP: begin
          if (gap_diff < rbws_pkg::TIME_W'(cfg.min_gap)) begin
            state <= ST_DONE;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (slot_down && k_q == rbws_pkg::KIND_POWER) begin
            // Drop every entry of a disconnected slot, then move to the other slot or finish
            for (int j = 0; j < rbws_pkg::KINDS; j++) begin
              pending[rbws_pkg::entry_index(cur_slot, 2'(j))] <= 1'b0;
            end
            if (pass_q) begin
              state <= ST_DONE;
            end else begin
              pass_q <= 1'b1;
            end
          end else if (pending[cur_idx]) begin
            state <= ST_CHECK;
          end else if (scan_last) begin
            state <= ST_DONE;
          end else if (k_q == rbws_pkg::KIND_COLOR) begin
            pass_q <= 1'b1;
            k_q    <= rbws_pkg::KIND_POWER;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_CHECK: begin
          if (entry_due) begin
            res_issued      <= 1'b1;
            res_slot        <= cur_slot;
            res_kind        <= k_q;
            res_value       <= rd_entry.value;
            last_write_time <= now_q;
            next_slot       <= ~cur_slot;
            if (ok_q && sends_dec == '0) begin
              pending[cur_idx] <= 1'b0;
            end
            state <= ST_DONE;
          end else if (scan_last) begin
            state <= ST_DONE;
          end else if (k_q == rbws_pkg::KIND_COLOR) begin
            pass_q <= 1'b1;
            k_q    <= rbws_pkg::KIND_POWER;
            state  <= ST_SCAN;
          end else begin
            k_q   <= k_q + 2'd1;
            state <= ST_SCAN;
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_issued <= res_issued;
            out_slot   <= res_slot;
            out_kind   <= res_kind;
            out_value  <= res_value;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.write_issued = out_issued;
  assign rsp.write_slot   = out_slot;
  assign rsp.write_kind   = out_kind;
  assign rsp.write_value  = out_value;

endmodule
